### sv/b2r_pkg.sv
`timescale 1ns / 1ps

package b2r_pkg;

    localparam int unsigned VALUE_W = 14;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned DIGIT_W = 4;

    localparam logic [VALUE_W-1:0] LIMIT_ERROR    = 14'd10000;
    localparam logic [VALUE_W-1:0] LIMIT_VINCULUM = 14'd4000;

    localparam logic [VALUE_W-1:0] W_THOU = 14'd1000;
    localparam logic [VALUE_W-1:0] W_HUND = 14'd100;
    localparam logic [VALUE_W-1:0] W_TENS = 14'd10;
    localparam logic [VALUE_W-1:0] W_ONES = 14'd1;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5F;
    localparam logic [CHAR_W-1:0] CHAR_I     = 7'h49;
    localparam logic [CHAR_W-1:0] CHAR_V     = 7'h56;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h58;
    localparam logic [CHAR_W-1:0] CHAR_L     = 7'h4C;
    localparam logic [CHAR_W-1:0] CHAR_C     = 7'h43;
    localparam logic [CHAR_W-1:0] CHAR_D     = 7'h44;
    localparam logic [CHAR_W-1:0] CHAR_M     = 7'h4D;

    // one decoded request, front to back
    typedef struct packed {
        logic               err;
        logic               vinc;
        logic [DIGIT_W-1:0] thou;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } entry_t;

    typedef enum logic [1:0] {
        SEL_ONE  = 2'd0,
        SEL_FIVE = 2'd1,
        SEL_TEN  = 2'd2
    } sym_sel_t;

    // characters a decimal digit takes in a numeral
    function automatic logic [2:0] pat_len(input logic [DIGIT_W-1:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // which symbol of the decade sits at a given position
    function automatic sym_sel_t pat_sym(input logic [DIGIT_W-1:0] d, input logic [1:0] pos);
        sym_sel_t s;
        s = SEL_ONE;
        case (d)
            4'd4:          s = (pos == 2'd0) ? SEL_ONE : SEL_FIVE;
            4'd9:          s = (pos == 2'd0) ? SEL_ONE : SEL_TEN;
            4'd5, 4'd6, 4'd7, 4'd8:
                           s = (pos == 2'd0) ? SEL_FIVE : SEL_ONE;
            default:       s = SEL_ONE;
        endcase
        return s;
    endfunction

endpackage

### sv/binary_to_roman_numeral.sv
`timescale 1ns / 1ps

// channel   handshake                 payload
// -------   -----------------------   ---------------------------
// value     value_valid/value_ready   value[13:0]
// char      char_valid/char_ready     char_code[6:0], too_large, last
//
// Front splits a request into decimal digits (take, four digit steps,
// hand-off) and parks it in a 2-entry queue. Back sends one character per
// cycle from a registered output while char_ready allows, plus a load step
// per request; a zero digit passes through with nothing sent.
// Front and back overlap, so a new value is taken while the back still sends.
// Reset (rst_n, async) empties the queue and the output register.
// Either side stalls on its own; char_ready low holds the current character.

module binary_to_roman_numeral
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        value_valid,
    output logic                        value_ready,
    input  logic [b2r_pkg::VALUE_W-1:0] value,
    output logic                        char_valid,
    input  logic                        char_ready,
    output logic [b2r_pkg::CHAR_W-1:0]  char_code,
    output logic                        too_large,
    output logic                        last
);
    import b2r_pkg::*;

    logic   push, full, pop, empty;
    entry_t push_entry, head;

    b2r_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .push        (push),
        .push_entry  (push_entry),
        .full        (full)
    );

    b2r_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    b2r_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .too_large  (too_large),
        .last       (last)
    );

endmodule

### sv/b2r_front.sv
`timescale 1ns / 1ps

module b2r_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        value_valid,
    output logic                        value_ready,
    input  logic [b2r_pkg::VALUE_W-1:0] value,
    output logic                        push,
    output b2r_pkg::entry_t             push_entry,
    input  logic                        full
);
    import b2r_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_SPLIT = 3'b010,
        F_PUSH  = 3'b100
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 err_reg, vinc_reg;
    logic [DIGIT_W-1:0]   digit_reg [4];
    logic [VALUE_W-1:0]   weight;
    logic [DIGIT_W-1:0]   dig;
    logic [VALUE_W-1:0]   sub;

    // greedy digit: largest k with k*w <= rem
    function automatic logic [DIGIT_W+VALUE_W-1:0] split_digit(
        input logic [VALUE_W-1:0] rem,
        input logic [VALUE_W-1:0] w
    );
        logic [DIGIT_W-1:0] d;
        logic [VALUE_W-1:0] s;
        d = '0;
        s = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem >= VALUE_W'(k) * w)
            begin
                d = DIGIT_W'(k);
                s = VALUE_W'(k) * w;
            end
        end
        return {d, s};
    endfunction

    always_comb
    begin
        case (idx_reg)
            2'd0:    weight = W_THOU;
            2'd1:    weight = W_HUND;
            2'd2:    weight = W_TENS;
            default: weight = W_ONES;
        endcase
        {dig, sub} = split_digit(rem_reg, weight);
    end

    assign value_ready = (state_reg == F_IDLE);
    assign push        = (state_reg == F_PUSH) && !full;

    assign push_entry.err  = err_reg;
    assign push_entry.vinc = vinc_reg;
    assign push_entry.thou = digit_reg[0];
    assign push_entry.hund = digit_reg[1];
    assign push_entry.tens = digit_reg[2];
    assign push_entry.ones = digit_reg[3];

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (value_valid)
                begin
                    rem_next   = value;
                    idx_next   = 2'd0;
                    state_next = F_SPLIT;
                end
            end
            F_SPLIT:
            begin
                rem_next = rem_reg - sub;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (state_reg == F_IDLE && value_valid)
        begin
            err_reg  <= (value >= LIMIT_ERROR);
            vinc_reg <= (value >= LIMIT_VINCULUM) && (value < LIMIT_ERROR);
        end
        if (state_reg == F_SPLIT)
        begin
            digit_reg[idx_reg] <= dig;
        end
    end

endmodule

### sv/b2r_queue.sv
`timescale 1ns / 1ps

module b2r_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b2r_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output b2r_pkg::entry_t head,
    output logic            empty
);
    import b2r_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### sv/b2r_back.sv
`timescale 1ns / 1ps

module b2r_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  b2r_pkg::entry_t            head,
    input  logic                       empty,
    output logic                       pop,
    output logic                       char_valid,
    input  logic                       char_ready,
    output logic [b2r_pkg::CHAR_W-1:0] char_code,
    output logic                       too_large,
    output logic                       last
);
    import b2r_pkg::*;

    typedef enum logic [8:0] {
        P_IDLE   = 9'b000000001,
        P_ERR    = 9'b000000010,
        P_VOPEN  = 9'b000000100,
        P_THOU   = 9'b000001000,
        P_VCLOSE = 9'b000010000,
        P_HUND   = 9'b000100000,
        P_TENS   = 9'b001000000,
        P_ONES   = 9'b010000000,
        P_SPACE  = 9'b100000000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         pos_reg, pos_next;
    entry_t             cur_reg, cur_next;
    logic               char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0]  char_code_reg, char_code_next;
    logic               too_large_reg, too_large_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  c_one, c_five, c_ten;
    logic [2:0]         len;
    logic [CHAR_W-1:0]  sym_char;
    phase_t             after_digit;

    assign out_free = !char_valid_reg || char_ready;

    // digit and decade symbols for the current phase
    always_comb
    begin
        digit       = cur_reg.ones;
        c_one       = CHAR_I;
        c_five      = CHAR_V;
        c_ten       = CHAR_X;
        after_digit = P_SPACE;
        case (phase_reg)
            P_THOU:
            begin
                digit = cur_reg.thou;
                if (cur_reg.vinc)
                begin
                    after_digit = P_VCLOSE;
                end
                else
                begin
                    // below 4000 thousands are only M repeats
                    c_one       = CHAR_M;
                    c_five      = CHAR_M;
                    c_ten       = CHAR_M;
                    after_digit = P_HUND;
                end
            end
            P_HUND:
            begin
                digit       = cur_reg.hund;
                c_one       = CHAR_C;
                c_five      = CHAR_D;
                c_ten       = CHAR_M;
                after_digit = P_TENS;
            end
            P_TENS:
            begin
                digit       = cur_reg.tens;
                c_one       = CHAR_X;
                c_five      = CHAR_L;
                c_ten       = CHAR_C;
                after_digit = P_ONES;
            end
            default:
            begin
                after_digit = P_SPACE;
            end
        endcase
        len = pat_len(digit);
        case (pat_sym(digit, pos_reg))
            SEL_FIVE: sym_char = c_five;
            SEL_TEN:  sym_char = c_ten;
            default:  sym_char = c_one;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        pop             = 1'b0;
        char_valid_next = char_valid_reg && !char_ready;
        char_code_next  = char_code_reg;
        too_large_next  = too_large_reg;
        last_next       = last_reg;
        case (phase_reg)
            P_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    pos_next = 2'd0;
                    if (head.err)
                    begin
                        phase_next = P_ERR;
                    end
                    else if (head.vinc)
                    begin
                        phase_next = P_VOPEN;
                    end
                    else
                    begin
                        phase_next = P_THOU;
                    end
                end
            end
            P_ERR:
            begin
                if (out_free)
                begin
                    char_valid_next = 1'b1;
                    char_code_next  = CHAR_NUL;
                    too_large_next  = 1'b1;
                    last_next       = 1'b1;
                    phase_next      = P_IDLE;
                end
            end
            P_VOPEN, P_VCLOSE:
            begin
                if (out_free)
                begin
                    char_valid_next = 1'b1;
                    char_code_next  = CHAR_UNDER;
                    too_large_next  = 1'b0;
                    last_next       = 1'b0;
                    phase_next      = (phase_reg == P_VOPEN) ? P_THOU : P_HUND;
                end
            end
            P_THOU, P_HUND, P_TENS, P_ONES:
            begin
                if (out_free)
                begin
                    // a zero digit just passes through with nothing sent
                    if ({1'b0, pos_reg} < len)
                    begin
                        char_valid_next = 1'b1;
                        char_code_next  = sym_char;
                        too_large_next  = 1'b0;
                        last_next       = 1'b0;
                    end
                    if ({1'b0, pos_reg} + 3'd1 >= len)
                    begin
                        pos_next   = 2'd0;
                        phase_next = after_digit;
                    end
                    else
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                end
            end
            P_SPACE:
            begin
                if (out_free)
                begin
                    char_valid_next = 1'b1;
                    char_code_next  = CHAR_SPACE;
                    too_large_next  = 1'b0;
                    last_next       = 1'b1;
                    phase_next      = P_IDLE;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_IDLE;
            pos_reg        <= 2'd0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        char_code_reg <= char_code_next;
        too_large_reg <= too_large_next;
        last_reg      <= last_next;
    end

    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign too_large  = too_large_reg;
    assign last       = last_reg;

endmodule
